### rtl/atrf_pkg.sv
// atrf_pkg: shared constants, types and the header byte table of the
// transmit-request framer. No dependencies.
`timescale 1ns / 1ps

package atrf_pkg;

  localparam int unsigned LEN_W       = 9;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 9'd256;
  localparam logic [15:0]      LEN_OFFSET  = 16'd14;

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] FRAME_TYPE  = 8'h10;
  localparam logic [7:0] FRAME_ID    = 8'h00;
  localparam logic [7:0] NET_ADDR_HI = 8'hFF;
  localparam logic [7:0] NET_ADDR_LO = 8'hFE;
  localparam logic [7:0] HOPS        = 8'h00;
  localparam logic [7:0] OPTIONS     = 8'h00;

  // header positions
  localparam logic [IDX_W-1:0] HDR_LEN_MSB = 5'd1;
  localparam logic [IDX_W-1:0] HDR_LAST    = 5'd16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LOW  = 2'd1;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // header byte at a given position, the start delimiter at position zero
  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                          input logic [15:0]      flen,
                                          input logic [31:0]      dhi,
                                          input logic [31:0]      dlo);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd0:    b = START_DELIM;
      5'd1:    b = flen[15:8];
      5'd2:    b = flen[7:0];
      5'd3:    b = FRAME_TYPE;
      5'd4:    b = FRAME_ID;
      5'd5:    b = dhi[31:24];
      5'd6:    b = dhi[23:16];
      5'd7:    b = dhi[15:8];
      5'd8:    b = dhi[7:0];
      5'd9:    b = dlo[31:24];
      5'd10:   b = dlo[23:16];
      5'd11:   b = dlo[15:8];
      5'd12:   b = dlo[7:0];
      5'd13:   b = NET_ADDR_HI;
      5'd14:   b = NET_ADDR_LO;
      5'd15:   b = HOPS;
      5'd16:   b = OPTIONS;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/atrf_seq.sv
// atrf_seq: frame sequencer; walks header, payload and checksum at most one byte
// per free output slot and keeps the running checksum. Uses atrf_pkg.
`timescale 1ns / 1ps

module atrf_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      hold_valid,
  input  logic [7:0]                hold_byte,
  input  logic [atrf_pkg::LEN_W-1:0] hold_len,
  input  logic [31:0]               dest_high,
  input  logic [31:0]               dest_low,
  input  logic                      slot_free,
  output atrf_pkg::emit_t           emit,
  output logic                      consume
);
  import atrf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_HDR, ST_BODY, ST_CSUM} state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_clamp;
  logic [15:0]       flen;

  always_comb begin
    if (hold_len == '0) begin
      len_clamp = LEN_W'(1);
    end else if (hold_len > MAX_PAYLOAD) begin
      len_clamp = MAX_PAYLOAD;
    end else begin
      len_clamp = hold_len;
    end
  end

  // length field counts payload plus the fixed part after the length
  assign flen = 16'(left_r) + LEN_OFFSET;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    emit      = '0;
    consume   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (hold_valid && slot_free) begin
          emit.vld  = 1'b1;
          emit.data = START_DELIM;
          left_nxt  = len_clamp;
          sum_nxt   = 8'h00;
          idx_nxt   = HDR_LEN_MSB;
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          emit.vld  = 1'b1;
          emit.data = hdr_byte(idx_r, flen, dest_high, dest_low);
          // the two length bytes stay out of the checksum
          if (idx_r > (HDR_LEN_MSB + IDX_W'(1))) begin
            sum_nxt = sum_r + emit.data;
          end
          if (idx_r == HDR_LAST) begin
            state_nxt = ST_BODY;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_BODY: begin
        if (hold_valid && slot_free) begin
          emit.vld  = 1'b1;
          emit.data = hold_byte;
          consume   = 1'b1;
          sum_nxt   = sum_r + hold_byte;
          left_nxt  = left_r - LEN_W'(1);
          if (left_r == LEN_W'(1)) begin
            state_nxt = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        if (slot_free) begin
          emit.vld  = 1'b1;
          emit.data = ~sum_r;
          emit.last = 1'b1;
          sum_nxt   = 8'h00;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
      sum_r   <= 8'h00;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### rtl/api_transmit_request_framer_core.sv
// api_transmit_request_framer_core: top level with destination registers,
// input request register, frame sequencer and output register. Uses atrf_pkg, atrf_seq.
`timescale 1ns / 1ps

// Usage:
//   in_*   carries payload bytes; in_payload_length is read only on the first
//          byte of a message (0 counts as 1, above 256 saturates to 256).
//   out_*  carries frame bytes; out_frame_end marks the checksum byte.
//   cfg_*  writes the destination address (index 0 upper half, 1 lower half);
//          cfg_ready is always high, other indexes are ignored.
//   A request is taken when valid is high and stall is low.
// Data path: a taken byte passes the input register and then the output
//   register; the first byte of a message is preceded by 17 header bytes,
//   one per cycle while the output is not stalled.
// Throughput: one payload byte per cycle inside a message while the output
//   is not stalled; a message adds 17 header bytes and one checksum byte,
//   all from the single output register, which emits one frame byte per cycle unless stalled.
// Reset clears the destination registers, the checksum and the sequencer,
//   so the next byte starts a new frame.
// When the receiver stalls, the output byte holds and the input register
//   fills, after which in_stall rises.
module api_transmit_request_framer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_payload_byte,
  input  logic [atrf_pkg::LEN_W-1:0]   in_payload_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_frame_byte,
  output logic                         out_frame_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [atrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import atrf_pkg::*;

  logic [31:0]      dest_high_r, dest_low_r;
  logic             hold_valid_r;
  logic [7:0]       hold_byte_r;
  logic [LEN_W-1:0] hold_len_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_end_r;
  logic             slot_free;
  logic             consume;
  logic             in_take;
  emit_t            emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_high_r <= '0;
      dest_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_HIGH: dest_high_r <= cfg_data;
        REG_DEST_LOW:  dest_low_r  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // input register frees up in the same cycle its byte goes out
  assign in_stall = hold_valid_r && !consume;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_take) begin
      hold_valid_r <= 1'b1;
    end else if (consume) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte_r <= in_payload_byte;
      hold_len_r  <= in_payload_length;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  atrf_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid_r),
    .hold_byte  (hold_byte_r),
    .hold_len   (hold_len_r),
    .dest_high  (dest_high_r),
    .dest_low   (dest_low_r),
    .slot_free  (slot_free),
    .emit       (emit),
    .consume    (consume)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      out_byte_r <= emit.data;
      out_end_r  <= emit.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

endmodule
